>>> src/assert_macros.svh
// Assertion macros used by the top level of the find-and-replace block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising clock edge outside reset.
`define SFR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true outside reset.
`define SFR_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define SFR_ASSERT(label, clk, rst, prop, msg)
`define SFR_ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

>>> src/sfr_pkg.sv
// Types and constants of the stream find-and-replace block.
`default_nettype none

package sfr_pkg;

   localparam int MAX_PATTERN     = 16;
   localparam int MAX_REPLACEMENT = 16;
   localparam int BYTE_W          = 8;
   localparam int LEN_W           = 5;   // holds 0..31, enough for lengths 0..16
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 64;

   // Register map of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LOW      = 3'd0,
      CSR_PATTERN_HIGH     = 3'd1,
      CSR_PATTERN_LENGTH   = 3'd2,
      CSR_REPLACEMENT_LOW  = 3'd3,
      CSR_REPLACEMENT_HIGH = 3'd4,
      CSR_REPLACEMENT_LEN  = 3'd5
   } csr_idx_type;

   typedef logic [MAX_PATTERN-1:0][BYTE_W-1:0] bytes_type;

   // Burst of result bytes produced by one input transaction
   typedef struct packed {
      bytes_type         bytes;
      logic [LEN_W-1:0]  count;
      logic              present;
      logic              eos;
   } burst_type;

endpackage

`default_nettype wire

>>> src/sfr_window.sv
// Match window: pending bytes, pattern compare and burst generation.
`default_nettype none

module sfr_window (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       accept,
   input  wire logic [sfr_pkg::BYTE_W-1:0] data_byte,
   input  wire logic                       final_byte,
   input  wire sfr_pkg::bytes_type         pattern,
   input  wire logic [sfr_pkg::LEN_W-1:0]  plen,
   input  wire sfr_pkg::bytes_type         replacement,
   input  wire logic [sfr_pkg::LEN_W-1:0]  rlen,
   input  wire logic                       clear_window,
   output sfr_pkg::burst_type              burst
);

   sfr_pkg::bytes_type              win_ff, win_in;
   logic [sfr_pkg::LEN_W-1:0]       fill_ff, fill_in;
   logic [sfr_pkg::LEN_W-1:0]       fill_eff;
   sfr_pkg::bytes_type              app;
   logic                            full;
   logic                            match;
   logic [sfr_pkg::LEN_W-1:0]       cnt;

   // Append the incoming byte behind the pending ones
   always_comb begin
      fill_eff = (fill_ff >= plen) ? '0 : fill_ff;
      for (int i = 0; i < sfr_pkg::MAX_PATTERN; i++) begin
         app[i] = (fill_eff == sfr_pkg::LEN_W'(i)) ? data_byte : win_ff[i];
      end
      full = ((fill_eff + sfr_pkg::LEN_W'(1)) == plen);
   end

   // Parallel compare over the bytes in use
   always_comb begin
      match = 1'b1;
      for (int i = 0; i < sfr_pkg::MAX_PATTERN; i++) begin
         if ((sfr_pkg::LEN_W'(i) < plen) && (app[i] != pattern[i])) begin
            match = 1'b0;
         end
      end
   end

   // Burst contents and next window state
   always_comb begin
      win_in  = app;
      fill_in = fill_eff + sfr_pkg::LEN_W'(1);
      cnt     = '0;
      burst.bytes = app;
      if (full && match) begin
         burst.bytes = replacement;
         cnt         = rlen;
         fill_in     = '0;
      end else if (full) begin
         // oldest byte leaves; on the final transaction the rest follows it
         cnt     = final_byte ? plen : sfr_pkg::LEN_W'(1);
         fill_in = plen - sfr_pkg::LEN_W'(1);
         for (int i = 0; i < sfr_pkg::MAX_PATTERN - 1; i++) begin
            win_in[i] = app[i+1];
         end
      end else if (final_byte) begin
         cnt = fill_eff + sfr_pkg::LEN_W'(1);
      end
      if (final_byte) begin
         fill_in = '0;
      end
      // empty end marker
      burst.present = !(final_byte && (cnt == '0));
      burst.count   = burst.present ? cnt : sfr_pkg::LEN_W'(1);
      burst.eos     = final_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (clear_window) begin
         fill_ff <= '0;
      end else if (accept) begin
         fill_ff <= fill_in;
      end
      if (accept) begin
         win_ff <= win_in;
      end
   end

endmodule

`default_nettype wire

>>> src/stream_find_replace.sv
// Top level of the stream find-and-replace block.
//
// Usage: bytes enter on the req_ channel (valid/stall); each transaction carries one
// byte and a final flag. Rewritten bytes leave on the rsp_ channel, one per transaction,
// with byte_present and end_of_string. Pattern, replacement and their lengths are set
// through the csr_ write port (always ready) while the stream is idle; writing the
// pattern length discards any pending bytes.
// Latency: a result appears on rsp_ the cycle after the input transaction is taken.
// Throughput: one input byte per cycle while each byte yields at most one result and
// rsp_stall is low. A byte that yields more results (a replacement or the final flush)
// holds req_stall until its last result leaves the output burst register, which drains
// one byte per transaction. A new byte is taken in the same cycle the last one leaves.
// Reset (synchronous, active high) empties the window and the output burst and
// restores pattern length 1 and an empty replacement.
// When the receiver stalls, the current result holds and req_stall rises once the
// burst register is occupied.
`default_nettype none

`include "assert_macros.svh"

module stream_find_replace (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // input byte channel
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [sfr_pkg::BYTE_W-1:0]     req_data_byte,
   input  wire logic                           req_final_byte,
   // result channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [sfr_pkg::BYTE_W-1:0]          rsp_out_byte,
   output logic                                rsp_byte_present,
   output logic                                rsp_end_of_string,
   // configuration writes
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [sfr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sfr_pkg::CSR_DATA_W-1:0] csr_data
);

   logic [sfr_pkg::CSR_DATA_W-1:0] pat_lo_ff, pat_hi_ff, rep_lo_ff, rep_hi_ff;
   logic [sfr_pkg::LEN_W-1:0]      pat_len_ff, rep_len_ff;
   logic [sfr_pkg::LEN_W-1:0]      plen, rlen;
   logic                           csr_wr;
   logic                           clear_window;
   logic                           req_take, rsp_take;
   sfr_pkg::burst_type             burst;
   sfr_pkg::bytes_type             out_ff;
   logic [sfr_pkg::LEN_W-1:0]      cnt_ff;
   logic                           present_ff, eos_ff;

   // Configuration registers
   assign csr_ready    = 1'b1;
   assign csr_wr       = csr_valid && csr_ready;
   assign clear_window = csr_wr && (csr_index == sfr_pkg::CSR_PATTERN_LENGTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_lo_ff  <= '0;
         pat_hi_ff  <= '0;
         pat_len_ff <= sfr_pkg::LEN_W'(1);
         rep_lo_ff  <= '0;
         rep_hi_ff  <= '0;
         rep_len_ff <= '0;
      end else if (csr_wr) begin
         case (csr_index)
            sfr_pkg::CSR_PATTERN_LOW:      pat_lo_ff  <= csr_data;
            sfr_pkg::CSR_PATTERN_HIGH:     pat_hi_ff  <= csr_data;
            sfr_pkg::CSR_PATTERN_LENGTH:   pat_len_ff <= csr_data[sfr_pkg::LEN_W-1:0];
            sfr_pkg::CSR_REPLACEMENT_LOW:  rep_lo_ff  <= csr_data;
            sfr_pkg::CSR_REPLACEMENT_HIGH: rep_hi_ff  <= csr_data;
            sfr_pkg::CSR_REPLACEMENT_LEN:  rep_len_ff <= csr_data[sfr_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective lengths: zero pattern acts as one, both clamp at sixteen
   always_comb begin
      if (pat_len_ff == '0) begin
         plen = sfr_pkg::LEN_W'(1);
      end else if (pat_len_ff > sfr_pkg::LEN_W'(sfr_pkg::MAX_PATTERN)) begin
         plen = sfr_pkg::LEN_W'(sfr_pkg::MAX_PATTERN);
      end else begin
         plen = pat_len_ff;
      end
      if (rep_len_ff > sfr_pkg::LEN_W'(sfr_pkg::MAX_REPLACEMENT)) begin
         rlen = sfr_pkg::LEN_W'(sfr_pkg::MAX_REPLACEMENT);
      end else begin
         rlen = rep_len_ff;
      end
   end

   // Handshakes: take a new byte once the burst is empty or its last byte leaves
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign req_stall = !((cnt_ff == '0) ||
                        ((cnt_ff == sfr_pkg::LEN_W'(1)) && !rsp_stall));
   assign req_take  = req_valid && !req_stall;

   sfr_window u_window (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_take),
      .data_byte    (req_data_byte),
      .final_byte   (req_final_byte),
      .pattern      ({pat_hi_ff, pat_lo_ff}),
      .plen         (plen),
      .replacement  ({rep_hi_ff, rep_lo_ff}),
      .rlen         (rlen),
      .clear_window (clear_window),
      .burst        (burst)
   );

   // Output burst register, drained one byte per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (req_take) begin
         cnt_ff <= burst.count;
      end else if (rsp_take) begin
         cnt_ff <= cnt_ff - sfr_pkg::LEN_W'(1);
      end
      if (req_take) begin
         out_ff     <= burst.bytes;
         present_ff <= burst.present;
         eos_ff     <= burst.eos;
      end else if (rsp_take) begin
         for (int i = 0; i < sfr_pkg::MAX_PATTERN - 1; i++) begin
            out_ff[i] <= out_ff[i+1];
         end
      end
   end

   assign rsp_valid         = (cnt_ff != '0);
   assign rsp_out_byte      = present_ff ? out_ff[0] : '0;
   assign rsp_byte_present  = present_ff;
   assign rsp_end_of_string = eos_ff && (cnt_ff == sfr_pkg::LEN_W'(1));

   // Checks
   `SFR_ASSERT(a_take_drained, clock, reset, (req_valid && !req_stall) |-> (cnt_ff <= sfr_pkg::LEN_W'(1)), "byte taken while burst still pending")
   `SFR_ASSERT_NEVER(a_cnt_range, clock, reset, cnt_ff > sfr_pkg::LEN_W'(sfr_pkg::MAX_PATTERN), "burst count out of range")
   `SFR_ASSERT(a_empty_is_end, clock, reset, (rsp_valid && !rsp_byte_present) |-> rsp_end_of_string, "empty result not marked end")

endmodule

`default_nettype wire
